// File: rtl/b64lw_pkg.sv
package b64lw_pkg;

    localparam logic [6:0] LINE_LIMIT = 7'd76;
    localparam logic [6:0] GROUP_CHARS = 7'd4;
    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] CR_CHAR = 8'h0D;
    localparam logic [7:0] LF_CHAR = 8'h0A;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [2:0] IDX_SYM0 = 3'd0;
    localparam logic [2:0] IDX_SYM1 = 3'd1;
    localparam logic [2:0] IDX_SYM2 = 3'd2;
    localparam logic [2:0] IDX_SYM3 = 3'd3;
    localparam logic [2:0] IDX_CR = 3'd4;
    localparam logic [2:0] IDX_LF = 3'd5;

    typedef struct packed {
        logic [23:0] word;
        logic        sym2;
        logic        sym3;
        logic        crlf;
        logic        fin;
    } t_group;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        case (v) inside
            [6'd0:6'd25]:  b64_char = w + 8'd65;
            [6'd26:6'd51]: b64_char = w + 8'd71;
            [6'd52:6'd61]: b64_char = w - 8'd4;
            6'd62:         b64_char = 8'h2B;
            default:       b64_char = 8'h2F;
        endcase
    endfunction

endpackage

// File: rtl/b64lw_front.sv
module b64lw_front
    import b64lw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_fin,
    input  logic       i_full,
    output logic       o_push,
    output t_group     o_group
);

    logic [15:0] r_pend, n_pend;
    logic [1:0]  r_cnt, n_cnt;
    logic [6:0]  r_line, n_line;
    logic        accept;
    logic        complete;
    logic [6:0]  line_sum;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign complete = i_fin || (r_cnt == 2'd2);
    assign o_push   = accept && complete;
    assign line_sum = r_line + GROUP_CHARS;

    always_comb begin
        o_group.crlf = (line_sum >= LINE_LIMIT);
        o_group.fin  = i_fin;
        case (r_cnt)
            2'd0: begin
                o_group.word = {i_byte, 16'h0000};
                o_group.sym2 = 1'b0;
                o_group.sym3 = 1'b0;
            end
            2'd1: begin
                o_group.word = {r_pend[15:8], i_byte, 8'h00};
                o_group.sym2 = 1'b1;
                o_group.sym3 = 1'b0;
            end
            default: begin
                o_group.word = {r_pend, i_byte};
                o_group.sym2 = 1'b1;
                o_group.sym3 = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        n_line = r_line;
        if (accept) begin
            if (complete) begin
                n_pend = 16'h0000;
                n_cnt  = 2'd0;
                n_line = (o_group.crlf || i_fin) ? 7'd0 : line_sum;
            end else begin
                if (r_cnt == 2'd0) begin
                    n_pend = {i_byte, 8'h00};
                end else begin
                    n_pend = {r_pend[15:8], i_byte};
                end
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 16'h0000;
            r_cnt  <= 2'd0;
            r_line <= 7'd0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
            r_line <= n_line;
        end
    end

endmodule

// File: rtl/b64lw_fifo.sv
module b64lw_fifo
    import b64lw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_group o_group
);

    t_group             r_mem [FIFO_DEPTH];
    t_group             r_head;
    logic [FIFO_AW-1:0] r_wr, r_rd, n_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_group = r_head;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign n_rd    = do_pop ? r_rd + 1'b1 : r_rd;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_group;
        end
        if (do_push && (n_rd == r_wr)) begin
            r_head <= i_group;
        end else begin
            r_head <= r_mem[n_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            r_rd <= n_rd;
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/b64lw_back.sv
module b64lw_back
    import b64lw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_group     i_group,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char,
    output logic       o_last,
    output logic       o_end
);

    t_group     r_grp, n_grp;
    logic [2:0] r_idx, n_idx;
    logic       r_busy, n_busy;
    logic       r_oval, n_oval;
    logic [7:0] r_ochar, n_ochar;
    logic       r_olast, n_olast;
    logic       r_oend, n_oend;
    logic       adv;
    logic       is_last;
    logic       done;
    logic [7:0] cur_char;

    assign adv     = !r_oval || i_ready;
    assign is_last = (r_idx == (r_grp.crlf ? IDX_LF : IDX_SYM3));
    assign done    = !r_busy || (adv && is_last);
    assign o_pop   = done && i_valid;

    always_comb begin
        case (r_idx)
            IDX_SYM0: cur_char = b64_char(r_grp.word[23:18]);
            IDX_SYM1: cur_char = b64_char(r_grp.word[17:12]);
            IDX_SYM2: cur_char = r_grp.sym2 ? b64_char(r_grp.word[11:6]) : PAD_CHAR;
            IDX_SYM3: cur_char = r_grp.sym3 ? b64_char(r_grp.word[5:0]) : PAD_CHAR;
            IDX_CR:   cur_char = CR_CHAR;
            default:  cur_char = LF_CHAR;
        endcase
    end

    always_comb begin
        n_grp   = r_grp;
        n_idx   = r_idx;
        n_busy  = r_busy;
        n_oval  = r_oval;
        n_ochar = r_ochar;
        n_olast = r_olast;
        n_oend  = r_oend;
        if (adv) begin
            n_oval = r_busy;
            if (r_busy) begin
                n_ochar = cur_char;
                n_olast = is_last;
                n_oend  = is_last && r_grp.fin;
                n_idx   = r_idx + 3'd1;
            end
        end
        if (done) begin
            n_busy = i_valid;
            if (i_valid) begin
                n_grp = i_group;
                n_idx = IDX_SYM0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_oval <= 1'b0;
            r_idx  <= IDX_SYM0;
        end else begin
            r_busy <= n_busy;
            r_oval <= n_oval;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp   <= n_grp;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
        r_oend  <= n_oend;
    end

    assign o_valid = r_oval;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;
    assign o_end   = r_oend;

endmodule

// File: rtl/base64_encoder_line_wrap.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid / s_tready  tdata = data_byte, tlast = final_byte
// m_*       out  m_tvalid / m_tready  tdata = out_char, tlast = run_last,
//                                     tuser = message_end
// One byte is taken per cycle while the group queue (4 entries) has room.
// One character leaves per cycle while m_tready is high; a group is 4 characters, 6 with CR LF,
// so the output register, not the input, sets the sustained rate.
// Reset is synchronous, active low; it empties the queue and clears the line.
// A stalled output fills the queue; a full queue drops s_tready.
module base64_encoder_line_wrap
    import b64lw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,
    output logic       m_tuser    // [0] message_end
);

    logic   push, full, pop, q_valid;
    t_group front_grp, q_grp;

    b64lw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_byte  (s_tdata),
        .i_fin   (s_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_group (front_grp)
    );

    b64lw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (front_grp),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_group (q_grp)
    );

    b64lw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_group (q_grp),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_char  (m_tdata),
        .o_last  (m_tlast),
        .o_end   (m_tuser)
    );

endmodule

// File: tb/b64lw_checker.sv
module b64lw_checker
    import b64lw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,
    input  logic       i_m_tlast,
    input  logic       i_m_tuser,
    output int         o_fail_count,
    output int         o_chars_pending,
    output int         o_chars_checked,
    output int         o_line_breaks
);

    localparam logic [511:0] B64_SET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
    } t_enc_char;

    t_enc_char   expected_chars[$];
    logic [15:0] held_bytes = '0;
    logic [1:0]  held_count = '0;
    logic [6:0]  line_fill = '0;
    int          errors = 0;
    int          checked = 0;
    int          breaks = 0;

    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
        sextet_to_ascii = B64_SET[8 * (63 - int'(v)) +: 8];
    endfunction

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [23:0] grp;
        logic [7:0]  chars[6];
        int          nsym;
        int          n;
        t_enc_char   e;
        if (!fin && held_count < 2'd2) begin
            if (held_count == 2'd0) begin
                held_bytes = {b, 8'h00};
            end else begin
                held_bytes[7:0] = b;
            end
            held_count = held_count + 2'd1;
        end else begin
            case (held_count)
                2'd0: begin
                    grp = {b, 16'h0000};
                    nsym = 2;
                end
                2'd1: begin
                    grp = {held_bytes[15:8], b, 8'h00};
                    nsym = 3;
                end
                default: begin
                    grp = {held_bytes, b};
                    nsym = 4;
                end
            endcase
            chars[0] = sextet_to_ascii(grp[23:18]);
            chars[1] = sextet_to_ascii(grp[17:12]);
            chars[2] = (nsym >= 3) ? sextet_to_ascii(grp[11:6]) : PAD_CHAR;
            chars[3] = (nsym == 4) ? sextet_to_ascii(grp[5:0]) : PAD_CHAR;
            n = 4;
            held_bytes = '0;
            held_count = '0;
            line_fill = line_fill + GROUP_CHARS;
            if (line_fill >= LINE_LIMIT) begin
                line_fill = '0;
                chars[4] = CR_CHAR;
                chars[5] = LF_CHAR;
                n = 6;
                breaks++;
            end
            if (fin) begin
                line_fill = '0;
            end
            for (int i = 0; i < n; i++) begin
                e.ch = chars[i];
                e.run_last = (i == n - 1);
                e.msg_end = (i == n - 1) && fin;
                expected_chars.push_back(e);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_enc_char want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                encode_byte(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character %h with nothing pending", i_m_tdata);
                    errors++;
                end else begin
                    want = expected_chars.pop_front();
                    checked++;
                    if (i_m_tdata !== want.ch) begin
                        $error("out_char expected %h got %h", want.ch, i_m_tdata);
                        errors++;
                    end
                    if (i_m_tlast !== want.run_last) begin
                        $error("run_last expected %b got %b", want.run_last, i_m_tlast);
                        errors++;
                    end
                    if (i_m_tuser !== want.msg_end) begin
                        $error("message_end expected %b got %b", want.msg_end, i_m_tuser);
                        errors++;
                    end
                end
            end
        end
        o_fail_count <= errors;
        o_chars_pending <= expected_chars.size();
        o_chars_checked <= checked;
        o_line_breaks <= breaks;
    end

endmodule

// File: tb/tb_top.sv
module tb_top;
    import b64lw_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_BYTES = 500;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    logic       idle_on = 1'b0;
    int         rx_stall = 0;
    int         quiet_cycles = 0;
    int         fail_count;
    int         chars_pending;
    int         chars_checked;
    int         line_breaks;
    int         bytes_sent = 0;
    int         messages_sent = 0;

    base64_encoder_line_wrap DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    b64lw_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tlast       (m_tlast),
        .i_m_tuser       (m_tuser),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending),
        .o_chars_checked (chars_checked),
        .o_line_breaks   (line_breaks)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_stall <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fin;
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        bytes_sent++;
        if (fin) begin
            messages_sent++;
        end
    endtask

    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic drain_output();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (chars_pending != 0);
    endtask

    initial begin : stimulus
        int len;
        int pick;
        int random_start;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single byte, two bytes, full groups, '+' and '/' symbols
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        drain_output();

        idle_on <= 1'b1;
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                len = $urandom_range(1, 12);
            end else if (pick < 8) begin
                len = $urandom_range(50, 120);
            end else begin
                len = 55 + $urandom_range(0, 2) + 57 * $urandom_range(0, 1);
            end
            send_random_message(len);
            if (messages_sent == 20) begin
                drain_output();
            end
            if (bytes_sent - random_start >= RANDOM_BYTES - 80) begin
                idle_on <= 1'b0;
            end
        end
        drain_output();
        repeat (20) @(posedge i_clk);

        $display("encoded %0d messages from %0d bytes; %0d characters checked",
                 messages_sent, bytes_sent, chars_checked);
        $display("line breaks inserted: %0d, with random stalls on both channels",
                 line_breaks);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
